// ===== src/tkhk_pkg.sv =====
// Shared types and constants for the top-k hot key pool.
package tkhk_pkg;

    localparam int KEY_W       = 64;
    localparam int COUNT_W     = 8;
    localparam int SLOT_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int MAX_RESULTS = 16;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_DUMP  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUMP     = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [KEY_W-1:0]   key_tag;
        logic [COUNT_W-1:0] access_count;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                entry_valid;
        logic [KEY_W-1:0]    entry_key;
        logic [COUNT_W-1:0]  entry_count;
        logic                last;
    } t_out;

    typedef struct packed {
        logic               used;
        logic [COUNT_W-1:0] count;
        logic [KEY_W-1:0]   key;
    } t_entry;

    localparam t_entry EMPTY_ENTRY = '{used: 1'b0, count: '0, key: '0};

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_REMOVE,
        OP_INSERT,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic               full;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DUMP
    } t_state;

endpackage

// ===== src/tkhk_cell.sv =====
// One slot of the sorted pool: holds an entry and moves it to or from its neighbors.
module tkhk_cell import tkhk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_seen,
    output logic       o_seen,
    input  logic       i_ge_lo,
    input  logic       i_ge_hi,
    output logic       o_ge,
    input  t_entry     i_lower,
    input  t_entry     i_upper,
    output t_entry     o_entry,
    output logic       o_load
);

    t_entry r_entry;
    t_entry n_entry;
    logic   match;

    // A matching key at or below this slot means this slot takes its upper neighbor.
    assign match  = r_entry.used && (r_entry.key == i_ctrl.key);
    assign o_seen = i_seen | match;

    // Counts are ascending and entries packed, so this flag is monotonic along the row.
    assign o_ge = !r_entry.used || (r_entry.count >= i_ctrl.count);

    assign o_load = (i_ctrl.op == OP_INSERT) &&
                    (i_ctrl.full ? (!o_ge && i_ge_hi) : (o_ge && !i_ge_lo));

    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            OP_REMOVE: begin
                if (o_seen) begin
                    n_entry = i_upper;
                end
            end
            OP_INSERT: begin
                if (o_load) begin
                    n_entry = '{used: 1'b1, count: i_ctrl.count, key: i_ctrl.key};
                end else if (i_ctrl.full && !i_ge_hi) begin
                    n_entry = i_upper;
                end else if (!i_ctrl.full && i_ge_lo) begin
                    n_entry = i_lower;
                end
            end
            OP_ROTATE: begin
                n_entry = i_upper;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // The key tag carries no reset; only the used flag and the count are cleared.
    always_ff @(posedge i_clk) begin
        r_entry.key <= n_entry.key;
        if (!i_rst_n) begin
            r_entry.used  <= 1'b0;
            r_entry.count <= '0;
        end else begin
            r_entry.used  <= n_entry.used;
            r_entry.count <= n_entry.count;
        end
    end

endmodule

// ===== src/top_k_hot_key_pool_top.sv =====
// Top level of the top-k hot key pool: a row of slot cells and the command sequencer.
// An offer runs in two steps: the removal pass in the accept cycle, then the insertion,
// which waits for a free output register and writes the offer's transaction into it.
// A new transaction is taken only in the idle state; a dump walks the whole row by
// rotation, one slot per step, and holds a step while a result waits on output stall.
// Reset clears every slot's used flag and count; key tags are left as they are.
module top_k_hot_key_pool_top import tkhk_pkg::*; #(
    parameter int POOL_ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int IW = $clog2(POOL_ENTRIES);

    // Sequencer state. The captured key and count feed the insertion cycle.
    t_state             r_state;
    t_state             n_state;
    logic [KEY_W-1:0]   r_key;
    logic [COUNT_W-1:0] r_count;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      n_idx;

    // Output register that decouples the row from the downstream side.
    logic r_out_valid;
    logic n_out_valid;
    t_out r_out;
    t_out n_out;
    logic out_free;
    logic out_load;

    // Row wiring.
    t_cell_ctrl    ctrl;
    t_entry        cell_entry [POOL_ENTRIES];
    logic          seen_out   [POOL_ENTRIES];
    logic          ge         [POOL_ENTRIES];
    logic          load       [POOL_ENTRIES];
    logic [IW-1:0] ins_slot;
    logic [IW+3:0] ins_slot_ext;
    logic [IW+3:0] idx_slot_ext;
    logic [8:0]    idx_ext;
    logic          in_accept;
    logic          full;
    logic          drop;
    logic          emit;
    logic          step;
    logic          dump_end;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The pool is full when the top slot is occupied, since entries are packed from slot 0.
    // A full pool drops the offer when its count is not above the lowest entry.
    assign full = cell_entry[POOL_ENTRIES-1].used;
    assign drop = full && ge[0];

    // The row of cells. Each cell sees its neighbors' entries and ordering flags;
    // the top cell takes an empty entry on removal and wraps to slot 0 on rotation.
    for (genvar g = 0; g < POOL_ENTRIES; g++) begin : g_cell
        t_entry lower;
        t_entry upper;
        logic   seen_in;
        logic   ge_lo;
        logic   ge_hi;

        if (g == 0) begin : g_first
            assign lower   = EMPTY_ENTRY;
            assign seen_in = 1'b0;
            assign ge_lo   = 1'b0;
        end else begin : g_mid_lo
            assign lower   = cell_entry[g-1];
            assign seen_in = seen_out[g-1];
            assign ge_lo   = ge[g-1];
        end

        if (g == POOL_ENTRIES - 1) begin : g_last
            assign upper = (ctrl.op == OP_ROTATE) ? cell_entry[0] : EMPTY_ENTRY;
            assign ge_hi = 1'b1;
        end else begin : g_mid_hi
            assign upper = cell_entry[g+1];
            assign ge_hi = ge[g+1];
        end

        tkhk_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_seen  (seen_in),
            .o_seen  (seen_out[g]),
            .i_ge_lo (ge_lo),
            .i_ge_hi (ge_hi),
            .o_ge    (ge[g]),
            .i_lower (lower),
            .i_upper (upper),
            .o_entry (cell_entry[g]),
            .o_load  (load[g])
        );
    end

    // Exactly one cell loads the new key on an insert; its position is the reported slot.
    always_comb begin
        ins_slot = '0;
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            if (load[i]) begin
                ins_slot = ins_slot | IW'(i);
            end
        end
    end

    assign ins_slot_ext = (IW + 4)'(ins_slot);
    assign idx_slot_ext = (IW + 4)'(r_idx);
    assign idx_ext      = 9'(r_idx);

    // During a dump the row rotates one slot per step, so slot 0 always holds the entry
    // at r_idx and slot 1 the one after it. Occupied entries form a prefix, so the
    // number reported so far equals r_idx. An empty pool still gives one transaction.
    assign emit = (idx_ext < 9'(MAX_RESULTS)) &&
                  (cell_entry[0].used || (r_idx == '0));
    assign step = !emit || out_free;
    assign dump_end = (r_idx == IW'(POOL_ENTRIES - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_data.cmd == CMD_DUMP) ? ST_DUMP : ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (step && dump_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: cell command, dump index and the result to register.
    always_comb begin
        ctrl       = '{op: OP_HOLD, full: full, key: r_key, count: r_count};
        n_idx      = r_idx;
        out_load   = 1'b0;
        n_out      = '0;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                // The removal pass runs straight off the accepted transaction.
                if (in_accept && (i_in_data.cmd == CMD_OFFER)) begin
                    ctrl.op  = OP_REMOVE;
                    ctrl.key = i_in_data.key_tag;
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out.last   = 1'b1;
                    if (drop) begin
                        n_out.status = STAT_DROPPED;
                    end else begin
                        ctrl.op      = OP_INSERT;
                        n_out.status = STAT_INSERTED;
                        n_out.slot   = ins_slot_ext[SLOT_W-1:0];
                    end
                end
            end
            ST_DUMP: begin
                if (step) begin
                    ctrl.op = OP_ROTATE;
                    n_idx   = r_idx + 1'b1;
                end
                if (emit && out_free) begin
                    out_load          = 1'b1;
                    n_out.status      = STAT_DUMP;
                    n_out.slot        = idx_slot_ext[SLOT_W-1:0];
                    n_out.entry_valid = cell_entry[0].used;
                    n_out.entry_key   = cell_entry[0].used ? cell_entry[0].key : '0;
                    n_out.entry_count = cell_entry[0].count;
                    n_out.last        = dump_end || !cell_entry[0].used ||
                                        !cell_entry[1].used ||
                                        (idx_ext == 9'(MAX_RESULTS - 1));
                end
            end
            default: begin
                ctrl.op = OP_HOLD;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_key   <= i_in_data.key_tag;
            r_count <= i_in_data.access_count;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

endmodule
